FILE: rtl/dfr_pkg.sv
// Shared types, constants and helpers of the length-prefixed frame deframer.
package dfr_pkg;

  // Header layout
  localparam int HEADER_BYTES = 10;
  localparam int MAGIC_LEN    = 6;
  localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
  localparam int IDX_VERSION  = 6;
  localparam int IDX_MODE     = 7;
  localparam int IDX_METHOD   = 8;
  localparam int IDX_TOTAL    = 9;

  // Header legality limits
  localparam logic [3:0] MODE_MAX   = 4'h3;
  localparam logic [7:0] METHOD_MAX = 8'h09;

  // Result queue depth between parser and output stage
  localparam int QUEUE_DEPTH = 4;

  // Event codes
  localparam logic [2:0] EV_PAYLOAD    = 3'd0;
  localparam logic [2:0] EV_NO_DATA    = 3'd1;
  localparam logic [2:0] EV_ILLEGAL    = 3'd2;
  localparam logic [2:0] EV_HEARTBEAT  = 3'd3;
  localparam logic [2:0] EV_BAD_MAGIC  = 3'd4;
  localparam logic [2:0] EV_TOO_MANY   = 3'd5;
  localparam logic [2:0] EV_EMPTY_FRM  = 3'd6;

  // Configuration register indexes and reset values
  localparam logic CFG_HEARTBEAT  = 1'b0;
  localparam logic CFG_MAX_FRAMES = 1'b1;
  localparam logic [3:0] HEARTBEAT_RST  = 4'd0;
  localparam logic [7:0] MAX_FRAMES_RST = 8'd16;

  // One result item as it travels through the queue
  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data;
    logic       frame_last;
    logic       package_last;
    logic       request_last;
    logic [7:0] version_byte;
    logic [7:0] mode_byte;
    logic [7:0] method_code;
    logic [7:0] package_total;
  } dfr_item_t;

  // Parser output toward the queue
  typedef struct packed {
    logic      valid;
    dfr_item_t item;
  } dfr_res_t;

  // Expected magic byte at a header position
  function automatic logic [7:0] magic_byte(input logic [HDR_CNT_W-1:0] idx);
    logic [7:0] m;
    case (idx)
      HDR_CNT_W'(0): m = 8'h23;
      HDR_CNT_W'(1): m = 8'h4D;
      HDR_CNT_W'(2): m = 8'h46;
      HDR_CNT_W'(3): m = 8'h50;
      HDR_CNT_W'(4): m = 8'h54;
      HDR_CNT_W'(5): m = 8'h50;
      default:       m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/dfr_front.sv
// Byte parser: header collection, frame control and size decode, payload tagging.
module dfr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_vld,
  input  logic [7:0]       rx_byte,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [7:0]       cfg_data,
  output dfr_pkg::dfr_res_t res
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_CONTROL = 2'd1;
  localparam logic [1:0] PH_SIZE    = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam int CW = dfr_pkg::HDR_CNT_W;

  // Control state
  logic [1:0]    phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    size_last_r, size_last_nxt;
  logic          more_r, more_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [7:0]    frames_r, frames_nxt;
  logic [7:0]    pkgs_r, pkgs_nxt;
  logic          magic_ok_r, magic_ok_nxt;
  logic [3:0]    hb_code_r;
  logic [7:0]    max_frames_r;

  // Header store (no reset: always fully written before use)
  logic [7:0] hdr_ver_r, hdr_ver_nxt;
  logic [7:0] hdr_mode_r, hdr_mode_nxt;
  logic [7:0] hdr_meth_r, hdr_meth_nxt;
  logic [7:0] hdr_total_r, hdr_total_nxt;

  // Frame-close decision shared by empty frame and last payload byte
  logic [7:0] pkgs_inc;
  logic       close_pl;
  logic       close_rl;

  assign pkgs_inc = pkgs_r + 8'd1;
  assign close_pl = !more_r;
  assign close_rl = !more_r && (pkgs_inc == hdr_total_r);

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    size_last_nxt = size_last_r;
    more_nxt      = more_r;
    rem_nxt       = rem_r;
    frames_nxt    = frames_r;
    pkgs_nxt      = pkgs_r;
    magic_ok_nxt  = magic_ok_r;
    hdr_ver_nxt   = hdr_ver_r;
    hdr_mode_nxt  = hdr_mode_r;
    hdr_meth_nxt  = hdr_meth_r;
    hdr_total_nxt = hdr_total_r;
    res           = '0;

    if (byte_vld) begin
      case (phase_r)
        PH_CONTROL: begin
          size_last_nxt = rx_byte[1:0];
          more_nxt      = |rx_byte[3:2];
          rem_nxt       = '0;
          cnt_nxt       = '0;
          frames_nxt    = frames_r + 8'd1;
          if (frames_nxt > max_frames_r) begin
            phase_nxt          = PH_HEADER;
            res.valid          = 1'b1;
            res.item.event_res = dfr_pkg::EV_TOO_MANY;
          end else begin
            phase_nxt = PH_SIZE;
          end
        end

        PH_SIZE: begin
          rem_nxt = {rem_r[23:0], rx_byte};
          if (cnt_r != CW'(size_last_r)) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            cnt_nxt = '0;
            if (rem_nxt == 32'd0) begin
              // empty frame closes right away
              res.valid             = 1'b1;
              res.item.event_res    = dfr_pkg::EV_EMPTY_FRM;
              res.item.frame_last   = 1'b1;
              res.item.package_last = close_pl;
              res.item.request_last = close_rl;
              if (!more_r) begin
                pkgs_nxt = pkgs_inc;
                if (close_rl) begin
                  phase_nxt = PH_HEADER;
                end else begin
                  frames_nxt = '0;
                  phase_nxt  = PH_CONTROL;
                end
              end else begin
                phase_nxt = PH_CONTROL;
              end
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end

        PH_PAYLOAD: begin
          rem_nxt            = rem_r - 32'd1;
          res.valid          = 1'b1;
          res.item.event_res = dfr_pkg::EV_PAYLOAD;
          res.item.data      = rx_byte;
          if (rem_nxt == 32'd0) begin
            res.item.frame_last   = 1'b1;
            res.item.package_last = close_pl;
            res.item.request_last = close_rl;
            if (!more_r) begin
              pkgs_nxt = pkgs_inc;
              if (close_rl) begin
                phase_nxt = PH_HEADER;
                cnt_nxt   = '0;
              end else begin
                frames_nxt = '0;
                phase_nxt  = PH_CONTROL;
              end
            end else begin
              phase_nxt = PH_CONTROL;
            end
          end
        end

        default: begin
          // header collection, magic checked as it arrives
          if (cnt_r < CW'(dfr_pkg::MAGIC_LEN)) begin
            magic_ok_nxt = ((cnt_r == '0) || magic_ok_r) &&
                           (rx_byte == dfr_pkg::magic_byte(cnt_r));
          end
          if (cnt_r == CW'(dfr_pkg::IDX_VERSION)) hdr_ver_nxt   = rx_byte;
          if (cnt_r == CW'(dfr_pkg::IDX_MODE))    hdr_mode_nxt  = rx_byte;
          if (cnt_r == CW'(dfr_pkg::IDX_METHOD))  hdr_meth_nxt  = rx_byte;
          if (cnt_r == CW'(dfr_pkg::IDX_TOTAL))   hdr_total_nxt = rx_byte;
          phase_nxt = PH_HEADER;
          if (cnt_r == CW'(dfr_pkg::HEADER_BYTES - 1)) begin
            cnt_nxt = '0;
            if (!magic_ok_r) begin
              res.valid          = 1'b1;
              res.item.event_res = dfr_pkg::EV_BAD_MAGIC;
            end else if ((hdr_mode_r[7:4] > dfr_pkg::MODE_MAX) ||
                         (hdr_mode_r[3:0] > dfr_pkg::MODE_MAX) ||
                         (hdr_meth_r > dfr_pkg::METHOD_MAX)) begin
              res.valid          = 1'b1;
              res.item.event_res = dfr_pkg::EV_ILLEGAL;
            end else if (hdr_meth_r == {4'd0, hb_code_r}) begin
              res.valid          = 1'b1;
              res.item.event_res = dfr_pkg::EV_HEARTBEAT;
            end else if (rx_byte == 8'd0) begin
              res.valid          = 1'b1;
              res.item.event_res = dfr_pkg::EV_NO_DATA;
            end else begin
              frames_nxt = '0;
              pkgs_nxt   = '0;
              phase_nxt  = PH_CONTROL;
            end
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      endcase
    end

    // every result carries the latest header
    res.item.version_byte  = hdr_ver_nxt;
    res.item.mode_byte     = hdr_mode_nxt;
    res.item.method_code   = hdr_meth_nxt;
    res.item.package_total = hdr_total_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      cnt_r       <= '0;
      size_last_r <= '0;
      more_r      <= 1'b0;
      rem_r       <= '0;
      frames_r    <= '0;
      pkgs_r      <= '0;
      magic_ok_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      size_last_r <= size_last_nxt;
      more_r      <= more_nxt;
      rem_r       <= rem_nxt;
      frames_r    <= frames_nxt;
      pkgs_r      <= pkgs_nxt;
      magic_ok_r  <= magic_ok_nxt;
    end
  end

  // Header store
  always_ff @(posedge clk) begin
    hdr_ver_r   <= hdr_ver_nxt;
    hdr_mode_r  <= hdr_mode_nxt;
    hdr_meth_r  <= hdr_meth_nxt;
    hdr_total_r <= hdr_total_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_code_r    <= dfr_pkg::HEARTBEAT_RST;
      max_frames_r <= dfr_pkg::MAX_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dfr_pkg::CFG_HEARTBEAT:  hb_code_r    <= cfg_data[3:0];
        dfr_pkg::CFG_MAX_FRAMES: max_frames_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/dfr_queue.sv
// Short result queue between the parser and the output stage.
module dfr_queue #(
  parameter int DEPTH = dfr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  dfr_pkg::dfr_item_t wr_item,
  input  logic               rd_en,
  output dfr_pkg::dfr_item_t rd_item,
  output logic               not_empty,
  output logic               full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dfr_pkg::dfr_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign rd_item   = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == CW'(DEPTH));

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/dfr_back.sv
// Output stage: holds the oldest result and splits the header fields.
module dfr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  dfr_pkg::dfr_item_t q_item,
  output logic               q_rd_en,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [2:0]         out_event_res,
  output logic [7:0]         out_data,
  output logic               out_frame_last,
  output logic               out_package_last,
  output logic               out_request_last,
  output logic [3:0]         out_version,
  output logic [3:0]         out_revision,
  output logic [3:0]         out_compress_mode,
  output logic [3:0]         out_encrypt_mode,
  output logic [7:0]         out_method_code,
  output logic [7:0]         out_package_total
);

  logic               vld_r;
  dfr_pkg::dfr_item_t item_r;

  // Refill whenever the held item leaves or none is held
  assign q_rd_en = q_not_empty && (!vld_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_rd_en) begin
      vld_r <= 1'b1;
    end else if (out_pop) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en) begin
      item_r <= q_item;
    end
  end

  // Field split toward the ports
  assign out_empty         = !vld_r;
  assign out_event_res     = item_r.event_res;
  assign out_data          = item_r.data;
  assign out_frame_last    = item_r.frame_last;
  assign out_package_last  = item_r.package_last;
  assign out_request_last  = item_r.request_last;
  assign out_version       = item_r.version_byte[7:4];
  assign out_revision      = item_r.version_byte[3:0];
  assign out_compress_mode = item_r.mode_byte[7:4];
  assign out_encrypt_mode  = item_r.mode_byte[3:0];
  assign out_method_code   = item_r.method_code;
  assign out_package_total = item_r.package_total;

endmodule

FILE: rtl/length_prefixed_frame_deframer.sv
// Top level of the length-prefixed frame deframer. Takes one received byte per
// clock while in_full is low and gives at most one result item per byte: payload
// bytes tagged with frame, package and request closure, and header or framing
// events. The parser handles every byte in the cycle it is accepted, so the
// sustained rate is one byte per cycle; a result enters the result queue at the
// edge that accepts its byte and reaches the output ports through the output
// register. full rises only when the QUEUE_DEPTH-entry result queue is full,
// which happens only while the consumer holds off pop. The header fields on
// every result are those of the most recently gathered header. The user must
// write configuration only while idle; the block does not enforce it.
module length_prefixed_frame_deframer #(
  parameter int QUEUE_DEPTH = dfr_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [2:0] out_event_res,
  output logic [7:0] out_data,
  output logic       out_frame_last,
  output logic       out_package_last,
  output logic       out_request_last,
  output logic [3:0] out_version,
  output logic [3:0] out_revision,
  output logic [3:0] out_compress_mode,
  output logic [3:0] out_encrypt_mode,
  output logic [7:0] out_method_code,
  output logic [7:0] out_package_total,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  dfr_pkg::dfr_res_t  res;
  dfr_pkg::dfr_item_t q_item;
  logic               q_full;
  logic               q_not_empty;
  logic               q_rd_en;

  assign in_full = q_full;

  // Front: parse accepted bytes
  dfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (in_push && !q_full),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  // Queue between parser and output
  dfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (res.valid),
    .wr_item   (res.item),
    .rd_en     (q_rd_en),
    .rd_item   (q_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back: output register
  dfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_item            (q_item),
    .q_rd_en           (q_rd_en),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_event_res     (out_event_res),
    .out_data          (out_data),
    .out_frame_last    (out_frame_last),
    .out_package_last  (out_package_last),
    .out_request_last  (out_request_last),
    .out_version       (out_version),
    .out_revision      (out_revision),
    .out_compress_mode (out_compress_mode),
    .out_encrypt_mode  (out_encrypt_mode),
    .out_method_code   (out_method_code),
    .out_package_total (out_package_total)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the length-prefixed frame deframer.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 120;
  localparam logic [7:0] SYNC_WORD [dfr_pkg::MAGIC_LEN] =
    '{8'h23, 8'h4D, 8'h46, 8'h50, 8'h54, 8'h50};

  // Parser phases of the local model
  typedef enum logic [1:0] {ST_HDR, ST_CTRL, ST_LEN, ST_BODY} parse_st_t;

  // One expected result item
  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] data;
    logic       fl;
    logic       pl;
    logic       rl;
    logic [7:0] ver;
    logic [7:0] mode;
    logic [7:0] meth;
    logic [7:0] total;
  } deframe_res_t;

  // Directed stimulus rows: predicted, known silent, or typed-in result
  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_RESULT} row_kind_t;
  typedef struct packed {
    logic [7:0] b;
    row_kind_t  kind;
    logic [2:0] ev;
    logic [7:0] data;
    logic       fl;
    logic       pl;
    logic       rl;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [27] = '{
    // valid header: max version byte, max legal mode and method, one package
    '{8'h23, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h4D, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h46, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h50, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h54, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h50, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'hFF, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h33, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h09, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h01, ROW_SILENT,  dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    // empty frame with more set, one size byte
    '{8'h0C, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h00, ROW_RESULT,  dfr_pkg::EV_EMPTY_FRM, 8'h00, 1'b1, 1'b0, 1'b0},
    // closing frame, two size bytes, payload at both extremes
    '{8'hF1, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h00, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h02, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'hFF, ROW_RESULT,  dfr_pkg::EV_PAYLOAD, 8'hFF, 1'b0, 1'b0, 1'b0},
    '{8'h00, ROW_RESULT,  dfr_pkg::EV_PAYLOAD, 8'h00, 1'b1, 1'b1, 1'b1},
    // header with a broken first sync byte
    '{8'h00, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h4D, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h46, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h50, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h54, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h50, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h00, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h00, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h00, ROW_PREDICT, dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h00, ROW_RESULT,  dfr_pkg::EV_BAD_MAGIC, 8'h00, 1'b0, 1'b0, 1'b0}
  };

  // DUT connections
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [2:0] out_event_res;
  logic [7:0] out_data;
  logic       out_frame_last;
  logic       out_package_last;
  logic       out_request_last;
  logic [3:0] out_version;
  logic [3:0] out_revision;
  logic [3:0] out_compress_mode;
  logic [3:0] out_encrypt_mode;
  logic [7:0] out_method_code;
  logic [7:0] out_package_total;
  logic       cfg_we = 1'b0;
  logic       cfg_index = dfr_pkg::CFG_HEARTBEAT;
  logic [7:0] cfg_data = 8'h00;

  // Local model of the parser and its registers
  parse_st_t  state = ST_HDR;
  logic [7:0] hdr_store [dfr_pkg::HEADER_BYTES] = '{default: 8'h00};
  logic [3:0] cnt = 4'd0;
  logic [2:0] len_bytes = 3'd0;
  logic       more_flag = 1'b0;
  logic [31:0] bytes_left = 32'd0;
  logic [7:0] frame_cnt = 8'd0;
  logic [7:0] pkg_cnt = 8'd0;
  logic [3:0] hb_code = dfr_pkg::HEARTBEAT_RST;
  logic [7:0] frame_limit = dfr_pkg::MAX_FRAMES_RST;

  deframe_res_t pending_res [$];
  dir_row_t     typed_q [$];
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int items_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;

  length_prefixed_frame_deframer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_event_res    (out_event_res),
    .out_data         (out_data),
    .out_frame_last   (out_frame_last),
    .out_package_last (out_package_last),
    .out_request_last (out_request_last),
    .out_version      (out_version),
    .out_revision     (out_revision),
    .out_compress_mode(out_compress_mode),
    .out_encrypt_mode (out_encrypt_mode),
    .out_method_code  (out_method_code),
    .out_package_total(out_package_total),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // End of a frame: set closure flags and pick the next phase
  function automatic void finish_frame(inout deframe_res_t r);
    r.fl = 1'b1;
    if (more_flag) begin
      state = ST_CTRL;
    end else begin
      r.pl = 1'b1;
      pkg_cnt = pkg_cnt + 8'd1;
      if (pkg_cnt == hdr_store[dfr_pkg::IDX_TOTAL]) begin
        r.rl = 1'b1;
        state = ST_HDR;
        cnt = 4'd0;
      end else begin
        frame_cnt = 8'd0;
        state = ST_CTRL;
      end
    end
  endfunction

  // Advance the model by one byte; returns 1 when the byte yields a result
  function automatic bit deframe_byte(input logic [7:0] b, output deframe_res_t r);
    bit got;
    bit sync_ok;
    int i;
    got = 1'b0;
    r = '0;
    case (state)
      ST_CTRL: begin
        len_bytes = {1'b0, b[1:0]} + 3'd1;
        more_flag = |b[3:2];
        bytes_left = 32'd0;
        cnt = 4'd0;
        frame_cnt = frame_cnt + 8'd1;
        if (frame_cnt > frame_limit) begin
          state = ST_HDR;
          got = 1'b1;
          r.ev = dfr_pkg::EV_TOO_MANY;
        end else begin
          state = ST_LEN;
        end
      end
      ST_LEN: begin
        bytes_left = {bytes_left[23:0], b};
        cnt = cnt + 4'd1;
        if (cnt >= len_bytes) begin
          cnt = 4'd0;
          if (bytes_left == 32'd0) begin
            got = 1'b1;
            r.ev = dfr_pkg::EV_EMPTY_FRM;
            finish_frame(r);
          end else begin
            state = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        bytes_left = bytes_left - 32'd1;
        got = 1'b1;
        r.ev = dfr_pkg::EV_PAYLOAD;
        r.data = b;
        if (bytes_left == 32'd0) finish_frame(r);
      end
      default: begin
        if (cnt >= dfr_pkg::HEADER_BYTES) cnt = 4'd0;
        hdr_store[cnt] = b;
        cnt = cnt + 4'd1;
        if (cnt == dfr_pkg::HEADER_BYTES) begin
          cnt = 4'd0;
          got = 1'b1;
          sync_ok = 1'b1;
          for (i = 0; i < dfr_pkg::MAGIC_LEN; i++)
            if (hdr_store[i] != SYNC_WORD[i]) sync_ok = 1'b0;
          if (!sync_ok) begin
            r.ev = dfr_pkg::EV_BAD_MAGIC;
          end else if (hdr_store[dfr_pkg::IDX_MODE][7:4] > dfr_pkg::MODE_MAX
                       || hdr_store[dfr_pkg::IDX_MODE][3:0] > dfr_pkg::MODE_MAX
                       || hdr_store[dfr_pkg::IDX_METHOD] > dfr_pkg::METHOD_MAX) begin
            r.ev = dfr_pkg::EV_ILLEGAL;
          end else if (hdr_store[dfr_pkg::IDX_METHOD] == {4'h0, hb_code}) begin
            r.ev = dfr_pkg::EV_HEARTBEAT;
          end else if (hdr_store[dfr_pkg::IDX_TOTAL] == 8'd0) begin
            r.ev = dfr_pkg::EV_NO_DATA;
          end else begin
            got = 1'b0;
            frame_cnt = 8'd0;
            pkg_cnt = 8'd0;
            state = ST_CTRL;
          end
        end
      end
    endcase
    r.ver = hdr_store[dfr_pkg::IDX_VERSION];
    r.mode = hdr_store[dfr_pkg::IDX_MODE];
    r.meth = hdr_store[dfr_pkg::IDX_METHOD];
    r.total = hdr_store[dfr_pkg::IDX_TOTAL];
    return got;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Watch both handshakes; predict on accepted items, check popped results
  always @(posedge clk) begin : monitor
    deframe_res_t r;
    deframe_res_t want;
    dir_row_t     row;
    bit           has;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[length_prefixed_frame_deframer] ERROR");
      $finish;
    end else if (rst_n) begin
      if (in_push && !in_full) begin
        has = deframe_byte(in_rx_byte, r);
        if (typed_q.size() != 0) begin
          row = typed_q.pop_front();
          if (row.kind == ROW_SILENT) begin
            has = 1'b0;
          end else if (row.kind == ROW_RESULT) begin
            has = 1'b1;
            r.ev = row.ev;
            r.data = row.data;
            r.fl = row.fl;
            r.pl = row.pl;
            r.rl = row.rl;
          end
        end
        if (has) pending_res.push_back(r);
      end
      if (out_pop && !out_empty) begin
        if (pending_res.size() == 0) begin
          $error("result with nothing pending: event %0d data %0h", out_event_res, out_data);
          fail_cnt++;
        end else begin
          want = pending_res.pop_front();
          check_field("event_res", want.ev, out_event_res);
          check_field("data", want.data, out_data);
          check_field("frame_last", want.fl, out_frame_last);
          check_field("package_last", want.pl, out_package_last);
          check_field("request_last", want.rl, out_request_last);
          check_field("version", want.ver[7:4], out_version);
          check_field("revision", want.ver[3:0], out_revision);
          check_field("compress_mode", want.mode[7:4], out_compress_mode);
          check_field("encrypt_mode", want.mode[3:0], out_encrypt_mode);
          check_field("method_code", want.meth, out_method_code);
          check_field("package_total", want.total, out_package_total);
        end
      end
    end
  end

  // Result side: random pop, with one long hold-off on request
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one item, with random idle cycles ahead of it; returns once accepted
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  // One frame: control byte, big-endian size, payload
  task automatic send_frame(input bit more);
    int len;
    int sz;
    int k;
    len = $urandom_range(0, 3);
    sz = ($urandom_range(0, 99) < 25) ? 0 : $urandom_range(1, 6);
    push_byte({4'($urandom), more ? 2'($urandom_range(1, 3)) : 2'b00, 2'(len)});
    for (k = len; k >= 0; k--) push_byte(8'(sz >> (8 * k)));
    repeat (sz) push_byte(8'($urandom));
  endtask

  // One header and, when it is valid, its packages; always ends back at header
  task automatic send_request();
    logic [7:0] h [dfr_pkg::HEADER_BYTES];
    logic [7:0] meth;
    int kind;
    int npk;
    int full_pk;
    int nfr;
    int top;
    int j;
    int p;
    int f;
    bit ok;
    bit overflow;
    for (j = 0; j < dfr_pkg::MAGIC_LEN; j++) h[j] = SYNC_WORD[j];
    h[dfr_pkg::IDX_VERSION] = 8'($urandom);
    h[dfr_pkg::IDX_MODE] = {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))};
    do meth = 8'($urandom_range(0, 9)); while (meth == {4'h0, hb_code});
    h[dfr_pkg::IDX_METHOD] = meth;
    top = (frame_limit > 3) ? 3 : frame_limit;
    overflow = 1'b0;
    // long requests only where a frame overflow can end them cheaply
    if (frame_limit <= 16 && $urandom_range(0, 99) < 20) begin
      overflow = 1'b1;
      npk = $urandom_range(0, 1) ? 255 : $urandom_range(4, 254);
    end else begin
      npk = $urandom_range(1, 3);
      overflow = (frame_limit <= 16) && ($urandom_range(0, 99) < 10);
    end
    h[dfr_pkg::IDX_TOTAL] = 8'(npk);
    kind = $urandom_range(0, 99);
    ok = 1'b0;
    if (kind < 8) begin
      j = $urandom_range(0, dfr_pkg::MAGIC_LEN - 1);
      h[j] = h[j] ^ 8'($urandom_range(1, 255));
    end else if (kind < 12) begin
      // line noise
      for (j = 0; j < dfr_pkg::HEADER_BYTES; j++) h[j] = 8'($urandom);
      if (h[0] == SYNC_WORD[0]) h[0] = ~h[0];
    end else if (kind < 20) begin
      case ($urandom_range(0, 2))
        0: h[dfr_pkg::IDX_MODE][7:4] = 4'($urandom_range(4, 15));
        1: h[dfr_pkg::IDX_MODE][3:0] = 4'($urandom_range(4, 15));
        default: h[dfr_pkg::IDX_METHOD] = 8'($urandom_range(10, 255));
      endcase
    end else if (kind < 26) begin
      h[dfr_pkg::IDX_METHOD] = {4'h0, hb_code};
    end else if (kind < 31) begin
      h[dfr_pkg::IDX_TOTAL] = 8'd0;
    end else begin
      ok = 1'b1;
    end
    for (j = 0; j < dfr_pkg::HEADER_BYTES; j++) push_byte(h[j]);
    if (ok) begin
      full_pk = overflow ? $urandom_range(0, (npk - 1 > 2) ? 2 : npk - 1) : npk;
      for (p = 0; p < full_pk; p++) begin
        nfr = $urandom_range(1, top);
        for (f = 0; f < nfr; f++) send_frame(f < nfr - 1);
      end
      if (overflow) begin
        for (f = 0; f < frame_limit; f++) send_frame(1'b1);
        push_byte(8'($urandom));
      end
    end
  endtask

  // Write both registers once the block has drained
  task automatic set_config(input logic [3:0] hb, input logic [7:0] lim);
    in_push <= 1'b0;
    do @(posedge clk); while (pending_res.size() != 0);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= dfr_pkg::CFG_HEARTBEAT;
    cfg_data <= {4'h0, hb};
    @(posedge clk);
    cfg_index <= dfr_pkg::CFG_MAX_FRAMES;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    hb_code = hb;
    frame_limit = lim;
  endtask

  task automatic run_phase(input logic [3:0] hb, input logic [7:0] lim, input int tx, input int rx,
                           input bit hold, input int drain_after, input int quota);
    int stop;
    int drain_at;
    set_config(hb, lim);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    hold_req = hold;
    stop = items_sent + quota;
    drain_at = (drain_after != 0) ? items_sent + drain_after : 0;
    while (items_sent < stop) begin
      send_request();
      // sender pause until every pending result has come out
      if (drain_at != 0 && items_sent >= drain_at) begin
        in_push <= 1'b0;
        do @(posedge clk); while (pending_res.size() != 0);
        drain_at = 0;
      end
    end
  endtask

  // Main sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 8;
    rx_idle_pct = 74;
    foreach (DIR_TAB[i]) begin
      typed_q.push_back(DIR_TAB[i]);
      push_byte(DIR_TAB[i].b);
    end

    run_phase(4'd9, 8'd1, 8, 74, 1'b0, 0, 120);
    run_phase(4'd0, 8'd255, 8, 74, 1'b1, 0, 120);
    run_phase(4'd4, 8'd4, 74, 8, 1'b0, 60, 120);
    run_phase(4'($urandom_range(0, 9)), 8'($urandom_range(2, 16)), 0, 0, 1'b0, 0, 120);

    in_push <= 1'b0;
    do @(posedge clk); while (pending_res.size() != 0);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[length_prefixed_frame_deframer] OK");
    end else begin
      $display("[length_prefixed_frame_deframer] ERROR");
    end
    $finish;
  end

endmodule

FILE: length_prefixed_frame_deframer.f
rtl/dfr_pkg.sv
rtl/dfr_front.sv
rtl/dfr_queue.sv
rtl/dfr_back.sv
rtl/length_prefixed_frame_deframer.sv
tb/tb_top.sv
